>>> rtl/slkv_pkg.sv
// Shared types and codes of the sorted leaf key/value table.
package slkv_pkg;

    localparam int KEY_W  = 32;
    localparam int CNT_W  = 7;
    localparam int OUT_VW = 32;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_DUMP   = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_DUPLICATE = 3'd3;
    localparam logic [2:0] ST_ZERO_KEY  = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic compare;
        logic finish;
        logic rotate;
        logic emit_dump;
        logic dump_last;
        logic emit_empty;
    } slkv_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic             out_busy;
        logic [CNT_W-1:0] count;
    } slkv_stat_t;

endpackage

>>> rtl/sorted_leaf_key_value_table.sv
// Insert and lookup: accept, compare, then load the result once the output register is
// free. Dump: one result beat per stored pair while the slot ring turns once; an empty
// table gives a single not-found beat. A new request is taken once the previous one has
// loaded its last result beat and, for a dump, the ring is back in place. Reset (rst_n,
// asynchronous, active low) empties the table.
module sorted_leaf_key_value_table #(
    parameter int ENTRIES    = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  logic [1:0]                  req_type,
    input  logic [slkv_pkg::KEY_W-1:0]  req_key,
    input  logic [31:0]                 req_value,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output logic [2:0]                  status,
    output logic [slkv_pkg::KEY_W-1:0]  out_key,
    output logic [slkv_pkg::OUT_VW-1:0] out_value,
    output logic [slkv_pkg::CNT_W-1:0]  fill_count,
    output logic                        last
);
    import slkv_pkg::*;

    // The controller sequences each request; the datapath holds the slot
    // cells, which compare against the request key all at once and shift
    // up by one slot on an insert. A dump turns the cells as a ring and
    // reports slot 0 on each beat.
    slkv_cmd_t  cmd;
    slkv_stat_t stat;

    slkv_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_type  (req_type),
        .stat      (stat),
        .cmd       (cmd)
    );

    // The output register lets a finished result wait for rsp_ready while
    // the controller already takes the next request.
    slkv_datapath #(
        .ENTRIES    (ENTRIES),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .req_type   (req_type),
        .req_key    (req_key),
        .req_value  (req_value),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .status     (status),
        .out_key    (out_key),
        .out_value  (out_value),
        .fill_count (fill_count),
        .last       (last)
    );

endmodule

>>> rtl/slkv_ctrl.sv
// Controller state machine of the sorted leaf key/value table.
module slkv_ctrl #(
    parameter int ENTRIES = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  logic [1:0]             req_type,
    input  slkv_pkg::slkv_stat_t   stat,
    output slkv_pkg::slkv_cmd_t    cmd
);
    import slkv_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_FIN,
        S_DUMP
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] idx_next;
    logic             idx_at_end;

    assign idx_at_end = (idx_reg == CNT_W'(ENTRIES - 1));

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    case (req_type)
                        REQ_INSERT, REQ_LOOKUP: state_next = S_CMP;
                        REQ_DUMP:
                        begin
                            state_next = S_DUMP;
                            idx_next   = '0;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_CMP:
            begin
                cmd.compare = 1'b1;
                state_next  = S_FIN;
            end
            S_FIN:
            begin
                if (!stat.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DUMP:
            begin
                if (stat.count == '0)
                begin
                    if (!stat.out_busy)
                    begin
                        cmd.emit_empty = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else if (idx_reg < stat.count)
                begin
                    // Slot 0 of the ring holds the pair to report.
                    if (!stat.out_busy)
                    begin
                        cmd.emit_dump = 1'b1;
                        cmd.dump_last = (idx_reg == stat.count - 1'b1);
                        cmd.rotate    = 1'b1;
                        idx_next      = idx_reg + 1'b1;
                        if (idx_at_end)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
                else
                begin
                    // Finish the full turn so the ring is back in place.
                    cmd.rotate = 1'b1;
                    idx_next   = idx_reg + 1'b1;
                    if (idx_at_end)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

`ifndef SYNTHESIS
    a_finish_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !stat.out_busy)
        else $error("result loaded while output register is busy");

    a_dump_emit_rotates: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_dump |-> (cmd.rotate && idx_reg < stat.count))
        else $error("dump beat without ring rotation");
`endif

endmodule

>>> rtl/slkv_datapath.sv
// Datapath of the sorted leaf key/value table: slot cells, compare and output register.
module slkv_datapath #(
    parameter int ENTRIES    = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  slkv_pkg::slkv_cmd_t        cmd,
    output slkv_pkg::slkv_stat_t       stat,
    input  logic [1:0]                 req_type,
    input  logic [slkv_pkg::KEY_W-1:0] req_key,
    input  logic [31:0]                req_value,
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output logic [2:0]                 status,
    output logic [slkv_pkg::KEY_W-1:0] out_key,
    output logic [slkv_pkg::OUT_VW-1:0] out_value,
    output logic [slkv_pkg::CNT_W-1:0] fill_count,
    output logic                       last
);
    import slkv_pkg::*;

    // Captured request.
    logic [1:0]            type_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [63:0]           req_value_wide;

    // Slot cells and fill count.
    logic [KEY_W-1:0]      key_cell_reg [ENTRIES];
    logic [VALUE_BITS-1:0] val_cell_reg [ENTRIES];
    logic [CNT_W-1:0]      count_reg;

    // Compare results.
    logic [ENTRIES-1:0]    ge_next;
    logic [ENTRIES-1:0]    eq_next;
    logic [ENTRIES-1:0]    ge_reg;
    logic [ENTRIES-1:0]    eq_reg;
    logic [ENTRIES-1:0]    ge_prev;

    // Result decision.
    logic                  found;
    logic                  key_zero;
    logic                  is_full;
    logic                  ins_ok;
    logic [VALUE_BITS-1:0] sel_val;
    logic [63:0]           sel_wide;
    logic [63:0]           head_wide;

    // Output register.
    logic                  rsp_valid_reg;
    logic [2:0]            status_reg;
    logic [KEY_W-1:0]      out_key_reg;
    logic [OUT_VW-1:0]     out_value_reg;
    logic [CNT_W-1:0]      fill_reg;
    logic                  last_reg;

    assign req_value_wide = 64'(req_value);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            type_reg <= req_type;
            key_reg  <= req_key;
            val_reg  <= req_value_wide[VALUE_BITS-1:0];
        end
    end

    // Slots at or above the fill count count as "at least the key", so the
    // compare vector is a thermometer that starts at the insert position.
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (CNT_W'(i) < count_reg)
            begin
                ge_next[i] = (key_cell_reg[i] >= key_reg);
                eq_next[i] = (key_cell_reg[i] == key_reg);
            end
            else
            begin
                ge_next[i] = 1'b1;
                eq_next[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.compare)
        begin
            ge_reg <= ge_next;
            eq_reg <= eq_next;
        end
    end

    assign ge_prev  = {ge_reg[ENTRIES-2:0], 1'b0};
    assign found    = |eq_reg;
    assign key_zero = (key_reg == '0);
    assign is_full  = (count_reg >= CNT_W'(ENTRIES));
    assign ins_ok   = (type_reg == REQ_INSERT) && !key_zero && !found && !is_full;

    always_comb
    begin
        sel_val = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            sel_val = sel_val | (eq_reg[i] ? val_cell_reg[i] : '0);
        end
    end

    assign sel_wide  = 64'(sel_val);
    assign head_wide = 64'(val_cell_reg[0]);

    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_cell
        localparam int PRV = (g == 0) ? 0 : g - 1;
        localparam int NXT = (g == ENTRIES - 1) ? 0 : g + 1;

        always_ff @(posedge clk)
        begin
            if (cmd.finish && ins_ok)
            begin
                if (ge_reg[g] && !ge_prev[g])
                begin
                    key_cell_reg[g] <= key_reg;
                    val_cell_reg[g] <= val_reg;
                end
                else if (ge_prev[g])
                begin
                    key_cell_reg[g] <= key_cell_reg[PRV];
                    val_cell_reg[g] <= val_cell_reg[PRV];
                end
            end
            else if (cmd.rotate)
            begin
                key_cell_reg[g] <= key_cell_reg[NXT];
                val_cell_reg[g] <= val_cell_reg[NXT];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.finish && ins_ok)
        begin
            count_reg <= count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.finish || cmd.emit_dump || cmd.emit_empty)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_key_reg   <= key_reg;
            out_value_reg <= '0;
            fill_reg      <= count_reg;
            last_reg      <= 1'b1;
            if (key_zero)
            begin
                status_reg <= ST_ZERO_KEY;
            end
            else if (type_reg == REQ_INSERT)
            begin
                if (found)
                begin
                    status_reg <= ST_DUPLICATE;
                end
                else if (is_full)
                begin
                    status_reg <= ST_FULL;
                end
                else
                begin
                    status_reg <= ST_OK;
                    fill_reg   <= count_reg + 1'b1;
                end
            end
            else if (found)
            begin
                status_reg    <= ST_OK;
                out_value_reg <= sel_wide[OUT_VW-1:0];
            end
            else
            begin
                status_reg <= ST_NOT_FOUND;
            end
        end
        else if (cmd.emit_dump)
        begin
            status_reg    <= ST_OK;
            out_key_reg   <= key_cell_reg[0];
            out_value_reg <= head_wide[OUT_VW-1:0];
            fill_reg      <= count_reg;
            last_reg      <= cmd.dump_last;
        end
        else if (cmd.emit_empty)
        begin
            status_reg    <= ST_NOT_FOUND;
            out_key_reg   <= '0;
            out_value_reg <= '0;
            fill_reg      <= '0;
            last_reg      <= 1'b1;
        end
    end

    assign stat.out_busy = rsp_valid_reg && !rsp_ready;
    assign stat.count    = count_reg;

    assign rsp_valid  = rsp_valid_reg;
    assign status     = status_reg;
    assign out_key    = out_key_reg;
    assign out_value  = out_value_reg;
    assign fill_count = fill_reg;
    assign last       = last_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(ENTRIES))
        else $error("fill count above slot count");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && ins_ok) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("accepted insert did not grow the fill count");
`endif

endmodule

>>> tb/tb_sorted_leaf_key_value_table.sv
// Self-checking testbench for the sorted leaf key/value table: directed and random requests.
`timescale 1ns / 1ps

module tb_sorted_leaf_key_value_table;

    import slkv_pkg::*;

    localparam int ENTRIES    = 64;
    localparam int VALUE_BITS = 32;

    // Number of random requests that the block acts on; ignored request types come on top.
    localparam int RANDOM_REQS = 130;

    // The request type that the block ignores.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // The receiver stops for this long once this many result beats have arrived.
    // Meanwhile the sender keeps offering, so the block fills up and stalls its input.
    localparam int HOLD_AT     = 40;
    localparam int HOLD_CYCLES = 300;

    // Watchdog limit in cycles with no beat on either side. The slowest legal gap is the
    // long receiver hold above plus a dump walking the whole slot ring and a few random
    // stalls, so ten times that hold is far beyond any correct run.
    localparam int QUIET_LIMIT = 10 * HOLD_CYCLES;

    typedef struct {
        logic [1:0]       kind;
        logic [KEY_W-1:0] key;
        logic [31:0]      val;
    } leaf_req_t;

    typedef struct {
        logic [2:0]        status;
        logic [KEY_W-1:0]  key;
        logic [OUT_VW-1:0] val;
        logic [CNT_W-1:0]  fill;
        logic              last;
    } leaf_rsp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                req_valid = 1'b0;
    logic                req_ready;
    logic [1:0]          req_type = REQ_INSERT;
    logic [KEY_W-1:0]    req_key = '0;
    logic [31:0]         req_value = '0;
    logic                rsp_valid;
    logic                rsp_ready = 1'b0;
    logic [2:0]          status;
    logic [KEY_W-1:0]    out_key;
    logic [OUT_VW-1:0]   out_value;
    logic [CNT_W-1:0]    fill_count;
    logic                last;

    sorted_leaf_key_value_table #(
        .ENTRIES    (ENTRIES),
        .VALUE_BITS (VALUE_BITS)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req_type   (req_type),
        .req_key    (req_key),
        .req_value  (req_value),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .status     (status),
        .out_key    (out_key),
        .out_value  (out_value),
        .fill_count (fill_count),
        .last       (last)
    );

    // Requests waiting to be driven, and result beats that the leaf must still produce.
    leaf_req_t todo_req[$];
    leaf_rsp_t due_rsp[$];

    // Our own copy of the leaf: sorted keys in slots 0 .. leaf_fill-1.
    logic [KEY_W-1:0]      leaf_key[ENTRIES];
    logic [VALUE_BITS-1:0] leaf_val[ENTRIES];
    int unsigned           leaf_fill = 0;

    // Stimulus bookkeeping: every nonzero key ever offered for insert.
    bit                    seen_key[logic [KEY_W-1:0]];
    logic [KEY_W-1:0]      known_keys[$];

    int unsigned total_reqs = 0;
    int unsigned n_insert = 0, n_lookup = 0, n_dump = 0, n_ignored = 0;
    int unsigned phase_mark1 = 0, phase_mark2 = 0;

    // Counters shared between processes are written with nonblocking assignments only,
    // so that a reader at the same clock edge always sees the value from before it.
    int unsigned n_req_acc = 0;
    int unsigned n_rsp_acc = 0;
    int unsigned n_full_seen = 0;
    int unsigned n_errors = 0;
    int unsigned quiet_cycles = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;

    initial begin
        forever #4 clk = ~clk;
    end

    // Idle rates follow three stretches of the run, counted in accepted requests: first
    // the receiver is the slower side, then the sender, and at the end neither idles.
    function automatic int unsigned send_idle_pct();
        if (n_req_acc < phase_mark1)
            return 32;
        else if (n_req_acc < phase_mark2)
            return 49;
        return 0;
    endfunction

    function automatic int unsigned sink_idle_pct();
        if (n_req_acc < phase_mark1)
            return 49;
        else if (n_req_acc < phase_mark2)
            return 32;
        return 0;
    endfunction

    // Applies one accepted request to our copy of the leaf and queues the result beats it must
    // produce: one for insert or lookup, one per stored pair for a dump (one if the leaf is empty).
    task automatic apply_to_leaf(input leaf_req_t r);
        leaf_rsp_t   rs;
        int unsigned pos;
        int unsigned i;
        bit          hit;

        rs.status = ST_OK;
        rs.key    = r.key;
        rs.val    = '0;
        rs.fill   = CNT_W'(leaf_fill);
        rs.last   = 1'b1;

        case (r.kind)
            REQ_INSERT, REQ_LOOKUP:
            begin
                // First occupied slot whose key is at least the request key.
                pos = 0;
                while (pos < leaf_fill && leaf_key[pos] < r.key)
                    pos++;
                hit = (pos < leaf_fill) && (leaf_key[pos] == r.key);

                if (r.key == '0)
                    rs.status = ST_ZERO_KEY;
                else if (r.kind == REQ_LOOKUP)
                begin
                    if (hit)
                        rs.val = OUT_VW'(leaf_val[pos]);
                    else
                        rs.status = ST_NOT_FOUND;
                end
                else if (hit)
                    rs.status = ST_DUPLICATE;   // checked ahead of fullness
                else if (leaf_fill >= ENTRIES)
                    rs.status = ST_FULL;
                else
                begin
                    for (i = leaf_fill; i > pos; i--)
                    begin
                        leaf_key[i] = leaf_key[i-1];
                        leaf_val[i] = leaf_val[i-1];
                    end
                    leaf_key[pos] = r.key;
                    leaf_val[pos] = r.val[VALUE_BITS-1:0];
                    leaf_fill++;
                    rs.fill = CNT_W'(leaf_fill);
                end
                due_rsp.push_back(rs);
            end
            REQ_DUMP:
            begin
                if (leaf_fill == 0)
                begin
                    // An empty leaf answers a dump with a single not-found beat.
                    rs.status = ST_NOT_FOUND;
                    rs.key    = '0;
                    due_rsp.push_back(rs);
                end
                else
                begin
                    for (i = 0; i < leaf_fill; i++)
                    begin
                        rs.key  = leaf_key[i];
                        rs.val  = OUT_VW'(leaf_val[i]);
                        rs.last = (i + 1 == leaf_fill);
                        due_rsp.push_back(rs);
                    end
                end
            end
            default:
                ;   // the unused request type gives no result
        endcase
    endtask

    // Driver: takes the next request from the backlog once the current beat is gone, or
    // idles at the rate of the current stretch.
    always @(posedge clk or negedge rst_n)
    begin
        leaf_req_t nxt;

        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_type  <= REQ_INSERT;
            req_key   <= '0;
            req_value <= '0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                nxt.kind = req_type;
                nxt.key  = req_key;
                nxt.val  = req_value;
                apply_to_leaf(nxt);
                n_req_acc <= n_req_acc + 1;
            end
            if (!req_valid || req_ready)
            begin
                if (todo_req.size() != 0 && $urandom_range(0, 99) >= send_idle_pct())
                begin
                    nxt = todo_req.pop_front();
                    req_valid <= 1'b1;
                    req_type  <= nxt.kind;
                    req_key   <= nxt.key;
                    req_value <= nxt.val;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure, plus one long hold that lets the block back up.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            rsp_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && n_rsp_acc >= HOLD_AT)
        begin
            rsp_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
            rsp_ready <= ($urandom_range(0, 99) >= sink_idle_pct());
    end

    function automatic bit field_ok(input string what, input logic [31:0] want,
                                    input logic [31:0] got);
        if (want === got)
            return 1'b1;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
        return 1'b0;
    endfunction

    // Monitor: every result beat is checked against the oldest expectation.
    always @(posedge clk)
    begin
        leaf_rsp_t want;
        bit        ok;

        if (rst_n && rsp_valid && rsp_ready)
        begin
            n_rsp_acc <= n_rsp_acc + 1;
            if (status == ST_FULL)
                n_full_seen <= n_full_seen + 1;
            if (due_rsp.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, actual status %h key %h",
                         $time, status, out_key);
                n_errors <= n_errors + 1;
            end
            else
            begin
                want = due_rsp.pop_front();
                ok = field_ok("status", 32'(want.status), 32'(status))
                   & field_ok("out_key", want.key, out_key)
                   & field_ok("out_value", want.val, out_value)
                   & field_ok("fill_count", 32'(want.fill), 32'(fill_count))
                   & field_ok("last", 32'(want.last), 32'(last));
                if (!ok)
                    n_errors <= n_errors + 1;
            end
        end
    end

    // Watchdog: a long run of cycles with no beat on either channel means a hang.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= QUIET_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles, %0d results still due",
                         $time, QUIET_LIMIT, due_rsp.size());
                $display("sorted_leaf_key_value_table verification failed");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic add_req(input logic [1:0] kind, input logic [KEY_W-1:0] key,
                           input logic [31:0] val);
        leaf_req_t r;

        r.kind = kind;
        r.key  = key;
        r.val  = val;
        todo_req.push_back(r);
        case (kind)
            REQ_INSERT: n_insert++;
            REQ_LOOKUP: n_lookup++;
            REQ_DUMP:   n_dump++;
            default:    n_ignored++;
        endcase
        if (kind == REQ_INSERT && key != '0 && !seen_key.exists(key))
        begin
            seen_key[key] = 1'b1;
            known_keys.push_back(key);
        end
    endtask

    // Key spread: the full range, a dense low band that collides often, and the top end.
    function automatic logic [KEY_W-1:0] any_key();
        case ($urandom_range(0, 3))
            0, 1:    return $urandom;
            2:       return KEY_W'($urandom_range(1, 300));
            default: return 32'hFFFF_FF00 | KEY_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [KEY_W-1:0] fresh_key();
        logic [KEY_W-1:0] k;

        do
            k = any_key();
        while (k == '0 || seen_key.exists(k));
        return k;
    endfunction

    function automatic logic [KEY_W-1:0] old_key();
        return known_keys[$urandom_range(0, known_keys.size() - 1)];
    endfunction

    initial begin
        int unsigned n_rand;
        int unsigned roll;

        // Directed part on an empty leaf: empty dump, misses, zero keys, the ignored
        // request type, keys and values at both extremes, a shift into the middle,
        // a duplicate, and dumps of a small sorted leaf.
        add_req(REQ_DUMP,   '0,           '0);
        add_req(REQ_LOOKUP, 32'd5,        '0);
        add_req(REQ_INSERT, '0,           32'h1234_5678);
        add_req(REQ_LOOKUP, '0,           '0);
        add_req(REQ_UNUSED, 32'd7,        32'd7);
        add_req(REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_req(REQ_INSERT, 32'd1,        32'h0000_0000);
        add_req(REQ_INSERT, 32'h8000_0000, 32'h5A5A_5A5A);
        add_req(REQ_INSERT, 32'h7FFF_FFFF, 32'hA5A5_A5A5);
        add_req(REQ_INSERT, 32'd1,        32'd123);
        add_req(REQ_LOOKUP, 32'd1,        '0);
        add_req(REQ_LOOKUP, 32'hFFFF_FFFF, '0);
        add_req(REQ_LOOKUP, 32'h8000_0000, '0);
        add_req(REQ_LOOKUP, 32'd2,        '0);
        add_req(REQ_DUMP,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_req(REQ_UNUSED, '0,           32'hFFFF_FFFF);
        add_req(REQ_INSERT, 32'd2,        32'd1);
        add_req(REQ_DUMP,   '0,           '0);

        // Random part: mostly inserts and lookups of stored keys, so the leaf grows
        // toward full; duplicates, misses, zero keys and dumps mixed in.
        n_rand = 0;
        while (n_rand < RANDOM_REQS)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 45)
                add_req(REQ_INSERT, fresh_key(), $urandom);
            else if (roll < 55)
                add_req(REQ_INSERT, old_key(), $urandom);
            else if (roll < 75)
                add_req(REQ_LOOKUP, old_key(), $urandom);
            else if (roll < 85)
                add_req(REQ_LOOKUP, any_key(), $urandom);
            else if (roll < 90)
                add_req($urandom_range(0, 1) ? REQ_INSERT : REQ_LOOKUP, '0, $urandom);
            else if (roll < 95)
                add_req(REQ_DUMP, $urandom, $urandom);
            else
            begin
                add_req(REQ_UNUSED, $urandom, $urandom);
                continue;   // ignored requests do not count toward the random part
            end
            n_rand++;
        end

        // Make sure the leaf is full, then probe it: inserts of new keys must report full, then an
        // insert and a lookup of an offered key (duplicate if it is stored), and a full dump.
        while (seen_key.num() < ENTRIES + 3)
            add_req(REQ_INSERT, fresh_key(), $urandom);
        add_req(REQ_INSERT, old_key(), $urandom);
        add_req(REQ_LOOKUP, old_key(), '0);
        add_req(REQ_DUMP, '0, '0);

        total_reqs  = todo_req.size();
        phase_mark1 = total_reqs / 3;
        phase_mark2 = 2 * total_reqs / 3;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: every request taken, every expected beat seen, then a quiet tail long
        // enough for a full dump, so that a stray extra beat would still be caught.
        do
            @(posedge clk);
        while (n_req_acc != total_reqs);
        do
            @(posedge clk);
        while (due_rsp.size() != 0);
        repeat (ENTRIES + 16) @(posedge clk);

        $display("Run covered %0d requests: %0d inserts, %0d lookups, %0d dumps, %0d ignored.",
                 total_reqs, n_insert, n_lookup, n_dump, n_ignored);
        $display("%0d result beats checked; the leaf reached %0d pairs and refused %0d inserts.",
                 n_rsp_acc, leaf_fill, n_full_seen);
        if (n_errors == 0 && due_rsp.size() == 0)
            $display("sorted_leaf_key_value_table verification clean");
        else
            $display("sorted_leaf_key_value_table verification failed");
        $finish;
    end

endmodule
